// ===== hw/rtl/skl_pkg.sv =====
// ----------------------------------------------------------------------------
// skl_pkg: shared definitions of the sorted key list
// Capacity, derived widths, key type, status codes, sort modes and states.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef logic signed [7:0] key_t;
	typedef logic [CNT_W-1:0]  count_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	localparam logic [1:0] MODE_APPEND  = 2'd0;
	localparam logic [1:0] MODE_ASCEND  = 2'd1;
	localparam logic [1:0] MODE_DESCEND = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic report;
	} cmd_t;

endpackage

// ===== hw/rtl/skl_req_if.sv =====
// ----------------------------------------------------------------------------
// skl_req_if: request channel of the sorted key list
// Carries one insert or delete operation per transaction.
// ----------------------------------------------------------------------------
interface skl_req_if import skl_pkg::*; ();
	logic valid;
	logic ready;
	logic action;
	key_t key;

	modport source (output valid, output action, output key, input ready);
	modport sink   (input valid, input action, input key, output ready);
endinterface

// ===== hw/rtl/skl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// skl_rsp_if: response channel of the sorted key list
// Carries the status, count and end keys after each operation.
// ----------------------------------------------------------------------------
interface skl_rsp_if import skl_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] entry_count;
	key_t       head_key;
	key_t       tail_key;

	modport source (output valid, output status, output entry_count,
		output head_key, output tail_key, input ready);
	modport sink   (input valid, input status, input entry_count,
		input head_key, input tail_key, output ready);
endinterface

// ===== hw/rtl/skl_ctrl.sv =====
// ----------------------------------------------------------------------------
// skl_ctrl: sequencing of the sorted key list
// Accepts a request, runs the list update, then loads the response register.
// ----------------------------------------------------------------------------
module skl_ctrl import skl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The response register may be reloaded when it is empty or its transaction completes.
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_UPDATE;
			end
			S_UPDATE: state_d = S_REPORT;
			S_REPORT: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_UPDATE: cmd.update = 1'b1;
			S_REPORT: cmd.report = rsp_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.report) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hw/rtl/skl_datapath.sv =====
// ----------------------------------------------------------------------------
// skl_datapath: key cells, sort mode register and response register
// Each cell compares its key in parallel and shifts towards head or tail.
// ----------------------------------------------------------------------------
module skl_datapath import skl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cfg_en,
	input  logic [1:0] cfg_data,
	input  logic       req_action,
	input  key_t       req_key,
	output logic [1:0] rsp_status,
	output logic [4:0] rsp_entry_count,
	output key_t       rsp_head_key,
	output key_t       rsp_tail_key
);

	key_t       ent_q [CAPACITY];
	key_t       ent_d [CAPACITY];
	count_t     count_q, count_d;
	logic [1:0] mode_q;
	logic       action_q;
	key_t       key_q;
	status_t    status_q, status_d;

	logic [CAPACITY-1:0] occupied, pass, ahead, match, found_before;
	logic                hit, full, empty;

	logic [1:0]       out_status_q;
	logic [4:0]       out_count_q;
	key_t             out_head_q, out_tail_q;
	count_t           tail_pos;
	logic [CNT_W+4:0] count_ext;

	assign full  = (count_q >= count_t'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occupied[i] = (count_t'(i) < count_q);
			match[i]    = occupied[i] && (ent_q[i] == key_q);
			unique case (mode_q)
				MODE_ASCEND:  pass[i] = occupied[i] && (key_q > ent_q[i]);
				MODE_DESCEND: pass[i] = occupied[i] && (key_q < ent_q[i]);
				default:      pass[i] = occupied[i];
			endcase
		end
		// One-bit chains: cells up to and including the insert slot, cells past the match.
		ahead[0]        = 1'b1;
		found_before[0] = 1'b0;
		for (int i = 1; i < CAPACITY; i++) begin
			ahead[i]        = ahead[i-1] && pass[i-1];
			found_before[i] = found_before[i-1] || match[i-1];
		end
		hit = found_before[CAPACITY-1] || match[CAPACITY-1];
	end

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		for (int i = 0; i < CAPACITY; i++) ent_d[i] = ent_q[i];
		if (action_q == ACT_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + count_t'(1);
				for (int i = 0; i < CAPACITY; i++) begin
					if (ahead[i] && !pass[i]) ent_d[i] = key_q;
					else if (!ahead[i] && i > 0) ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else if (!hit) begin
				status_d = ST_MISSING;
			end else begin
				count_d = count_q - count_t'(1);
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (found_before[i] || match[i]) ent_d[i] = ent_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= MODE_ASCEND;
		end else begin
			if (cfg_en) mode_q <= cfg_data;
			if (cmd.update) count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req_action;
			key_q    <= req_key;
		end
		if (cmd.update) begin
			status_q <= status_d;
			for (int i = 0; i < CAPACITY; i++) ent_q[i] <= ent_d[i];
		end
	end

	// Response is taken from the updated cells in the report step.
	assign tail_pos  = count_q - count_t'(1);
	assign count_ext = {5'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			out_status_q <= status_q;
			out_count_q  <= count_ext[4:0];
			if (empty) begin
				out_head_q <= '0;
				out_tail_q <= '0;
			end else begin
				out_head_q <= ent_q[0];
				out_tail_q <= ent_q[tail_pos[IDX_W-1:0]];
			end
		end
	end

	assign rsp_status      = out_status_q;
	assign rsp_entry_count = out_count_q;
	assign rsp_head_key    = out_head_q;
	assign rsp_tail_key    = out_tail_q;

endmodule

// ===== hw/rtl/sorted_key_list.sv =====
// ----------------------------------------------------------------------------
// sorted_key_list: bounded ordered list of signed 8-bit keys
// Top level joining the sequencer and the key cell datapath.
// ----------------------------------------------------------------------------
// Each request transaction carries an action (insert or delete) and a key.
// Inserts go in ascending or descending order, or at the tail, as the sort
// mode register selects; a delete removes the first matching key from the
// head. Every request gives exactly one response transaction with a status,
// the count held afterwards and the head and tail keys (zero when empty).
// The sort mode is written through cfg_en and cfg_data; the user must write it
// only while no request is in flight, as the block does not enforce this.
// A request is accepted only in the idle state. The cells update in the cycle
// after acceptance, and the response register loads in the report step once
// it is free; a new request is accepted only when the sequencer is back in
// idle after the update and report steps of the last one. Reset empties the
// list and sets ascending mode; no clearing pass is needed. While the
// receiver stalls, the next request is still accepted and updated, and waits
// in the report step until the response register is free.
// ----------------------------------------------------------------------------
module sorted_key_list import skl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_en,
	input  logic [1:0] cfg_data,
	skl_req_if.sink    req,
	skl_rsp_if.source  rsp
);

	cmd_t cmd;

	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	skl_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_en          (cfg_en),
		.cfg_data        (cfg_data),
		.req_action      (req.action),
		.req_key         (req.key),
		.rsp_status      (rsp.status),
		.rsp_entry_count (rsp.entry_count),
		.rsp_head_key    (rsp.head_key),
		.rsp_tail_key    (rsp.tail_key)
	);

endmodule

// ===== hw/rtl/skl_checker.sv =====
// ----------------------------------------------------------------------------
// skl_checker: port level checks of the sorted key list
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module skl_checker import skl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [4:0] rsp_entry_count,
	input key_t       rsp_head_key,
	input key_t       rsp_tail_key
);

	// A stalled response keeps its valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped while stalled");

	// A stalled response keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_entry_count)
			&& $stable(rsp_head_key) && $stable(rsp_tail_key))
		else $error("response payload changed while stalled");

	// After an accepted request the block is busy for the update step.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted during the update step");

	// An empty list reports zero head and tail keys.
	a_empty_keys: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_entry_count == 5'd0 |-> rsp_head_key == '0 && rsp_tail_key == '0)
		else $error("empty list reports non-zero end keys");

	// A delete on an empty list leaves it empty.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == 5'd0)
		else $error("empty status with a non-zero count");

endmodule

bind sorted_key_list skl_checker u_skl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count),
	.rsp_head_key    (rsp.head_key),
	.rsp_tail_key    (rsp.tail_key)
);
